@@ design/anc_pw_pkg.sv @@
// Shared types and constants of the ancillary packet word packer.
package anc_pw_pkg;

    // Item operation codes.
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_WORD   = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_RESERVED_ID  = 3'd1;
    localparam logic [2:0] ST_RESERVED_SID = 3'd2;
    localparam logic [2:0] ST_NOT_TYPE1    = 3'd3;
    localparam logic [2:0] ST_BAD_WORD     = 3'd4;
    localparam logic [2:0] ST_SEQUENCE     = 3'd5;

    // Identifier table bounds.
    localparam logic [7:0] DID_T1_LO    = 8'h81;
    localparam logic [7:0] DID_T1_HI    = 8'h9F;
    localparam logic [7:0] DID_T2_LO    = 8'h04;
    localparam logic [7:0] DID_T2_HI    = 8'h0F;
    localparam logic [7:0] DID_T2_OK_A  = 8'h04;
    localparam logic [7:0] DID_T2_OK_B  = 8'h08;
    localparam logic [7:0] DID_T2_OK_C  = 8'h0C;

    // Upper two bits of a word that mark it as unusable.
    localparam logic [1:0] WORD_BAD_TOP = 2'b11;

    // Bytes one item can produce, and the depth of the job queue.
    localparam int JOB_BYTES   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       operation;
        logic [7:0] did;
        logic [7:0] second_byte;
        logic [7:0] word_count;
        logic       type1_only;
        logic [9:0] user_word;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [2:0] status;
    } out_item_t;

    // One accepted item after classification: the bytes it produces.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      last;
        logic [2:0]                status;
    } job_t;

endpackage

@@ design/anc_packet_word_packer.sv @@
// Top level of the ancillary packet word packer.
// An accepted item goes into the job queue as a job, from which the serialiser loads its first byte.
// Throughput: one byte per cycle while pop keeps up; each item yields 1 to 5 bytes, its byte count.
// A four-entry job queue lets headers and words be taken while earlier bytes still drain.
// Reset clears packet state, the queue pointers and the output valid flag; id_check_mode resets to 1.
module anc_packet_word_packer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  anc_pw_pkg::in_item_t  word_item,
    output logic                  empty,
    input  logic                  pop,
    output anc_pw_pkg::out_item_t byte_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import anc_pw_pkg::*;

    job_t front_job, head_job;
    logic take, job_ready, job_done;

    assign cfg_ready = 1'b1;
    assign take      = push && !full;

    // Classification and packet state.
    anc_pw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (word_item),
        .job       (front_job)
    );

    // Job queue.
    anc_pw_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (take),
        .wr_job    (front_job),
        .full      (full),
        .rd_en     (job_done),
        .rd_job    (head_job),
        .not_empty (job_ready)
    );

    // Byte serialiser.
    anc_pw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .job_ready (job_ready),
        .job_done  (job_done),
        .pop       (pop),
        .empty     (empty),
        .result    (byte_item)
    );

endmodule

@@ design/anc_pw_front.sv @@
// Front end: checks each item, keeps packet state and builds its byte job.
module anc_pw_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  logic                 take,
    input  anc_pw_pkg::in_item_t item,
    output anc_pw_pkg::job_t     job
);
    import anc_pw_pkg::*;

    logic       id_check_mode_reg, id_check_mode_next;
    logic       packet_open_reg, packet_open_next;
    logic [7:0] words_left_reg, words_left_next;
    logic [8:0] sum_acc_reg, sum_acc_next;
    logic [6:0] pending_bits_reg, pending_bits_next;
    logic [2:0] pending_count_reg, pending_count_next;

    logic [2:0]  hdr_status;
    logic [9:0]  w_did, w_sb, w_dc, w_user, cs_word;
    logic [8:0]  sum_new;
    logic        final_word;
    logic [39:0] words;
    logic [5:0]  nbits;
    logic [5:0]  total;
    logic [2:0]  nfull, rem;
    logic [47:0] stream, shifted;
    logic [7:0]  next_top;
    logic        is_error;
    logic [2:0]  err_status;

    // Parity for words whose upper bits are clear; others pass through.
    function automatic logic [9:0] with_parity(input logic [9:0] w);
        logic p;
        p = ^w[7:0];
        if (w[9:8] != 2'b00) begin
            return w;
        end
        return {~p, p, w[7:0]};
    endfunction

    // Header checks in priority order.
    always_comb
    begin
        hdr_status = ST_OK;
        if (item.type1_only && !item.did[7]) begin
            hdr_status = ST_NOT_TYPE1;
        end else if (!id_check_mode_reg) begin
            if (item.did == 8'h00) hdr_status = ST_RESERVED_ID;
        end else if (item.did[7]) begin
            if (item.did >= DID_T1_LO && item.did <= DID_T1_HI) hdr_status = ST_RESERVED_ID;
        end else if (item.did < DID_T2_LO) begin
            hdr_status = ST_RESERVED_ID;
        end else if (item.did <= DID_T2_HI && item.did != DID_T2_OK_A
                     && item.did != DID_T2_OK_B && item.did != DID_T2_OK_C) begin
            hdr_status = ST_RESERVED_ID;
        end else if (item.second_byte == 8'h00) begin
            hdr_status = ST_RESERVED_SID;
        end
    end

    // Words, checksum and the bit count that this item adds.
    always_comb
    begin
        w_did  = with_parity({2'b00, item.did});
        w_sb   = with_parity({2'b00, item.second_byte});
        w_dc   = with_parity({2'b00, item.word_count});
        w_user = with_parity(item.user_word);
        if (item.operation == OP_HEADER) begin
            sum_new    = w_did[8:0] + w_sb[8:0] + w_dc[8:0];
            final_word = (item.word_count == 8'h00);
        end else begin
            sum_new    = sum_acc_reg + w_user[8:0];
            final_word = (words_left_reg == 8'd1);
        end
        cs_word = {~sum_new[8], sum_new};
        if (item.operation == OP_HEADER) begin
            words = {w_did, w_sb, w_dc, final_word ? cs_word : 10'd0};
            nbits = final_word ? 6'd40 : 6'd30;
        end else begin
            words = {w_user, final_word ? cs_word : 10'd0, 20'd0};
            nbits = final_word ? 6'd20 : 6'd10;
        end
    end

    // Bit stream: waiting bits first, then the new words, MSB-first.
    always_comb
    begin
        stream   = ({pending_bits_reg, 41'd0} << (3'd7 - pending_count_reg))
                 | ({words, 8'd0} >> pending_count_reg);
        total    = {3'd0, pending_count_reg} + nbits;
        nfull    = total[5:3];
        rem      = total[2:0];
        shifted  = stream << {nfull, 3'b000};
        next_top = shifted[47:40];
    end

    // Classification into an error result or a run of packed bytes.
    always_comb
    begin
        is_error   = 1'b0;
        err_status = ST_OK;
        if (item.operation == OP_HEADER) begin
            if (packet_open_reg) begin
                is_error   = 1'b1;
                err_status = ST_SEQUENCE;
            end else if (hdr_status != ST_OK) begin
                is_error   = 1'b1;
                err_status = hdr_status;
            end
        end else begin
            if (!packet_open_reg) begin
                is_error   = 1'b1;
                err_status = ST_SEQUENCE;
            end else if (item.user_word[9:8] == WORD_BAD_TOP) begin
                is_error   = 1'b1;
                err_status = ST_BAD_WORD;
            end
        end
    end

    // Job for the queue and next packet state.
    always_comb
    begin
        id_check_mode_next = cfg_valid ? cfg_data : id_check_mode_reg;
        packet_open_next   = packet_open_reg;
        words_left_next    = words_left_reg;
        sum_acc_next       = sum_acc_reg;
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        for (int k = 0; k < JOB_BYTES; k++) begin
            job.bytes[k] = stream[47 - 8*k -: 8];
        end
        job.status = ST_OK;
        job.last   = final_word;
        job.count  = nfull + {2'b00, (final_word && rem != 3'd0)};
        if (is_error) begin
            job.bytes  = '0;
            job.count  = 3'd1;
            job.last   = 1'b1;
            job.status = err_status;
        end
        if (take) begin
            if (is_error || final_word) begin
                packet_open_next   = 1'b0;
                words_left_next    = 8'd0;
                sum_acc_next       = 9'd0;
                pending_bits_next  = 7'd0;
                pending_count_next = 3'd0;
            end else begin
                packet_open_next   = 1'b1;
                words_left_next    = (item.operation == OP_HEADER) ? item.word_count
                                                                   : words_left_reg - 8'd1;
                sum_acc_next       = sum_new;
                pending_bits_next  = 7'(next_top >> (4'd8 - {1'b0, rem}));
                pending_count_next = rem;
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            id_check_mode_reg <= 1'b1;
            packet_open_reg   <= 1'b0;
            words_left_reg    <= 8'd0;
            sum_acc_reg       <= 9'd0;
            pending_bits_reg  <= 7'd0;
            pending_count_reg <= 3'd0;
        end else begin
            id_check_mode_reg <= id_check_mode_next;
            packet_open_reg   <= packet_open_next;
            words_left_reg    <= words_left_next;
            sum_acc_reg       <= sum_acc_next;
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

@@ design/anc_pw_fifo.sv @@
// Short job queue between the front end and the byte serialiser.
module anc_pw_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  anc_pw_pkg::job_t wr_job,
    output logic             full,
    input  logic             rd_en,
    output anc_pw_pkg::job_t rd_job,
    output logic             not_empty
);
    import anc_pw_pkg::*;

    job_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;

    assign full      = (fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rd_job    = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en) fill_next = fill_reg + 1'b1;
        if (!wr_en && rd_en) fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

@@ design/anc_pw_back.sv @@
// Back end: walks the bytes of each queued job into the output register.
module anc_pw_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  anc_pw_pkg::job_t      job,
    input  logic                  job_ready,
    output logic                  job_done,
    input  logic                  pop,
    output logic                  empty,
    output anc_pw_pkg::out_item_t result
);
    import anc_pw_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;
    logic [2:0] byte_idx_reg, byte_idx_next;
    logic       load;
    logic       last_byte;

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

    // Move one byte whenever a job waits and the output register is free or being taken.
    always_comb
    begin
        load           = job_ready && (!out_valid_reg || pop);
        last_byte      = (byte_idx_reg == job.count - 3'd1);
        job_done       = load && last_byte;
        out_valid_next = load ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
        byte_idx_next  = byte_idx_reg;
        if (load) byte_idx_next = last_byte ? 3'd0 : byte_idx_reg + 3'd1;
        out_data_next.out_byte = job.bytes[byte_idx_reg];
        out_data_next.last     = job.last && last_byte;
        out_data_next.status   = job.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= 3'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            byte_idx_reg  <= byte_idx_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ design/anc_pw_checker.sv @@
// Port-level checks of the packer, bound to the top level.
module anc_pw_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input anc_pw_pkg::out_item_t byte_item
);
    import anc_pw_pkg::*;

    // A waiting result that is not taken stays unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(byte_item))
        else $error("result changed while stalled");

    // An error result is a single zero byte that closes the item.
    a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && byte_item.status != ST_OK |-> byte_item.last && byte_item.out_byte == 8'h00)
        else $error("malformed error result");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> byte_item.status <= ST_SEQUENCE)
        else $error("undefined status code");

    // A full queue always has a result waiting on the output side.
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full with no result waiting");

endmodule

bind anc_packet_word_packer anc_pw_checker u_anc_pw_checker (.*);

@@ tb/sv/tb_anc_packet_word_packer.sv @@
// Self-checking testbench for the ancillary packet word packer, with its own byte predictor.
module tb_anc_packet_word_packer;
    timeunit 1ns;
    timeprecision 1ps;

    import anc_pw_pkg::*;

    localparam int RANDOM_ITEMS = 280;
    localparam int PHASE_ITEMS  = 45;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 10;

    // One line of the directed plan: a register write, or an item with an optional fixed answer.
    typedef struct packed {
        logic      is_cfg;
        logic      cfg_value;
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  word_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t byte_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    // Predictor state: identifier check mode and the packet being built.
    logic       check_mode = 1'b1;
    logic       pk_open = 1'b0;
    logic [7:0] pk_left = '0;
    logic [8:0] pk_sum = '0;
    logic [6:0] pk_bits = '0;
    logic [2:0] pk_cnt = '0;

    out_item_t fresh[$];
    out_item_t bytes_due[$];

    logic calm = 1'b0;
    int   mismatches = 0;
    int   items_run = 0;
    int   bytes_checked = 0;
    int   packets_closed = 0;
    int   refusals = 0;
    int   mode_writes = 0;
    int   idle_cycles = 0;

    anc_packet_word_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .word_item (word_item),
        .empty     (empty),
        .pop       (pop),
        .byte_item (byte_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Adds parity to a word whose upper bits are clear; other words pass unchanged.
    function automatic logic [9:0] add_parity(input logic [9:0] w);
        logic p;
        if (w[9:8] != 2'b00)
            return w;
        p = ^w[7:0];
        return {~p, p, w[7:0]};
    endfunction

    // Verdict on a header under the current identifier check mode.
    function automatic logic [2:0] header_verdict(input logic [7:0] did, input logic [7:0] sb,
                                                  input logic t1);
        if (t1 && !did[7])
            return ST_NOT_TYPE1;
        if (!check_mode)
            return (did == 8'h00) ? ST_RESERVED_ID : ST_OK;
        if (did[7])
            return (did >= DID_T1_LO && did <= DID_T1_HI) ? ST_RESERVED_ID : ST_OK;
        if (did < DID_T2_LO)
            return ST_RESERVED_ID;
        if (did <= DID_T2_HI && did != DID_T2_OK_A && did != DID_T2_OK_B && did != DID_T2_OK_C)
            return ST_RESERVED_ID;
        if (sb == 8'h00)
            return ST_RESERVED_SID;
        return ST_OK;
    endfunction

    task automatic drop_packet();
        pk_open = 1'b0;
        pk_left = '0;
        pk_sum  = '0;
        pk_bits = '0;
        pk_cnt  = '0;
    endtask

    task automatic refuse(input logic [2:0] st);
        fresh.push_back(out_item_t'{out_byte: 8'h00, last: 1'b1, status: st});
    endtask

    // Shifts ten bits into the byte stream, MSB first, emitting each complete byte.
    task automatic shift_in_word(input logic [9:0] w);
        logic [16:0] v;
        int          cnt;
        v = {pk_bits, w};
        cnt = int'(pk_cnt) + 10;
        while (cnt >= 8)
        begin
            cnt -= 8;
            fresh.push_back(out_item_t'{out_byte: 8'(v >> cnt), last: 1'b0, status: ST_OK});
        end
        pk_bits = 7'(v & ((17'd1 << cnt) - 17'd1));
        pk_cnt  = 3'(cnt);
    endtask

    task automatic add_word(input logic [9:0] w);
        pk_sum = pk_sum + w[8:0];
        shift_in_word(w);
    endtask

    // Appends the checksum word, pads the final byte and marks it as the packet's end.
    task automatic close_packet();
        logic [15:0] tail;
        shift_in_word({~pk_sum[8], pk_sum});
        if (pk_cnt != 3'd0)
        begin
            tail = 16'(pk_bits) << (8 - int'(pk_cnt));
            fresh.push_back(out_item_t'{out_byte: tail[7:0], last: 1'b0, status: ST_OK});
        end
        fresh[fresh.size() - 1].last = 1'b1;
        drop_packet();
    endtask

    // Works out the bytes that one accepted item produces.
    task automatic pack_step(input in_item_t it);
        logic [2:0] st;
        fresh.delete();
        if (it.operation == OP_HEADER)
        begin
            if (pk_open)
            begin
                drop_packet();
                refuse(ST_SEQUENCE);
            end
            else
            begin
                st = header_verdict(it.did, it.second_byte, it.type1_only);
                if (st != ST_OK)
                    refuse(st);
                else
                begin
                    drop_packet();
                    add_word(add_parity({2'b00, it.did}));
                    add_word(add_parity({2'b00, it.second_byte}));
                    add_word(add_parity({2'b00, it.word_count}));
                    if (it.word_count == 8'h00)
                        close_packet();
                    else
                    begin
                        pk_open = 1'b1;
                        pk_left = it.word_count;
                    end
                end
            end
        end
        else if (!pk_open)
            refuse(ST_SEQUENCE);
        else if (it.user_word[9:8] == WORD_BAD_TOP)
        begin
            drop_packet();
            refuse(ST_BAD_WORD);
        end
        else
        begin
            add_word(add_parity(it.user_word));
            pk_left = pk_left - 8'd1;
            if (pk_left == 8'h00)
                close_packet();
        end
    endtask

    // Random values in every field, so that ignored fields toggle as well.
    function automatic in_item_t scramble();
        in_item_t it;
        it.operation   = 1'($urandom);
        it.did         = 8'($urandom);
        it.second_byte = 8'($urandom);
        it.word_count  = 8'($urandom);
        it.type1_only  = 1'($urandom);
        it.user_word   = 10'($urandom);
        return it;
    endfunction

    function automatic row_t step(input logic op, input logic [7:0] did, input logic [7:0] sb,
                                  input logic [7:0] dc, input logic t1, input logic [9:0] uw,
                                  input logic typed, input logic [2:0] st);
        row_t r;
        r = '0;
        r.item  = '{op, did, sb, dc, t1, uw};
        r.typed = typed;
        r.want  = '{8'h00, 1'b1, st};
        return r;
    endfunction

    function automatic row_t cfg_row(input logic m);
        row_t r;
        r = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = m;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Offers one item, waits for it to be taken and files its expected bytes.
    task automatic run_item(input in_item_t it, input logic typed, input out_item_t want);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        word_item <= it;
        do
            @(posedge clk);
        while (full);
        pack_step(it);
        if (typed)
            bytes_due.push_back(want);
        else
            foreach (fresh[i])
                bytes_due.push_back(fresh[i]);
        items_run++;
        @(negedge clk);
    endtask

    // Changes the identifier check mode once every expected byte has come out.
    task automatic set_check_mode(input logic m);
        push <= 1'b0;
        while (bytes_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        check_mode = m;
        mode_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: pop at random, with a stretch of steady popping.
    always @(negedge clk)
        pop <= calm || ($urandom_range(0, 99) >= 31);

    // Compare each byte taken with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (bytes_due.size() == 0)
                flag_mismatch($sformatf("unexpected byte %h last %b status %0d",
                                        byte_item.out_byte, byte_item.last, byte_item.status));
            else
            begin
                if (byte_item.out_byte !== bytes_due[0].out_byte)
                    flag_mismatch($sformatf("byte %0d: out_byte %h, expected %h", bytes_checked,
                                            byte_item.out_byte, bytes_due[0].out_byte));
                if (byte_item.last !== bytes_due[0].last)
                    flag_mismatch($sformatf("byte %0d: last %b, expected %b", bytes_checked,
                                            byte_item.last, bytes_due[0].last));
                if (byte_item.status !== bytes_due[0].status)
                    flag_mismatch($sformatf("byte %0d: status %0d, expected %0d", bytes_checked,
                                            byte_item.status, bytes_due[0].status));
                if (bytes_due[0].last && bytes_due[0].status == ST_OK)
                    packets_closed++;
                else if (bytes_due[0].last)
                    refusals++;
                void'(bytes_due.pop_front());
            end
            bytes_checked++;
        end
    end

    // Watchdog: ends the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_anc_packet_word_packer NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Stimulus: directed plan, then random packets over alternating check modes.
    initial
    begin
        row_t     plan[$];
        in_item_t it;
        int       base;
        int       phase;
        int       kind;
        int       dc;
        int       cut;
        int       spoil;

        plan = '{
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h000, 1'b1, ST_SEQUENCE),
            step(OP_HEADER, 8'h05, 8'h01, 8'h01, 1'b1, 10'h000, 1'b1, ST_NOT_TYPE1),
            step(OP_HEADER, 8'h00, 8'h01, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h81, 8'h01, 8'h01, 1'b1, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h9F, 8'h01, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h0F, 8'h01, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h0A, 8'hFF, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h04, 8'h00, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_SID),
            step(OP_HEADER, 8'hFF, 8'h00, 8'h00, 1'b1, 10'h3FF, 1'b0, ST_OK),
            step(OP_HEADER, 8'hA0, 8'hFF, 8'h03, 1'b1, 10'h000, 1'b0, ST_OK),
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h000, 1'b0, ST_OK),
            step(OP_WORD,   8'hFF, 8'hFF, 8'hFF, 1'b1, 10'h1FF, 1'b0, ST_OK),
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h2AA, 1'b0, ST_OK),
            step(OP_HEADER, 8'h08, 8'h01, 8'h02, 1'b0, 10'h000, 1'b0, ST_OK),
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h3FF, 1'b1, ST_BAD_WORD),
            step(OP_HEADER, 8'h0C, 8'h55, 8'hFF, 1'b0, 10'h000, 1'b0, ST_OK),
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h0FF, 1'b0, ST_OK),
            step(OP_HEADER, 8'h80, 8'h01, 8'h01, 1'b0, 10'h000, 1'b1, ST_SEQUENCE),
            cfg_row(1'b0),
            step(OP_HEADER, 8'h00, 8'h01, 8'h01, 1'b0, 10'h000, 1'b1, ST_RESERVED_ID),
            step(OP_HEADER, 8'h81, 8'h00, 8'h01, 1'b1, 10'h000, 1'b0, ST_OK),
            step(OP_WORD,   8'h00, 8'h00, 8'h00, 1'b0, 10'h155, 1'b0, ST_OK),
            step(OP_HEADER, 8'h10, 8'h01, 8'h01, 1'b1, 10'h000, 1'b1, ST_NOT_TYPE1),
            cfg_row(1'b1)
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                set_check_mode(plan[i].cfg_value);
            else
                run_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        base  = items_run;
        phase = 0;
        while (items_run - base < RANDOM_ITEMS)
        begin
            // Each phase starts with a mode change; the fourth runs without any idling.
            if (items_run - base >= phase * PHASE_ITEMS)
            begin
                set_check_mode(1'(phase % 2));
                calm = (phase == 3);
                phase++;
            end

            kind = $urandom_range(0, 99);
            if (kind < 75)
            begin
                // A well-formed packet, now and then spoilt by a bad word or cut short.
                dc = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
                spoil = (dc > 0 && $urandom_range(0, 9) == 0) ? $urandom_range(0, dc - 1) : -1;
                cut   = (dc > 0 && $urandom_range(0, 11) == 0) ? $urandom_range(0, dc - 1) : dc;

                it = scramble();
                it.operation  = OP_HEADER;
                it.word_count = 8'(dc);
                if (check_mode)
                begin
                    case ($urandom_range(0, 3))
                        0:       it.did = ($urandom_range(0, 7) == 0) ?
                                          8'h80 : 8'($urandom_range(8'hA0, 8'hFF));
                        1:
                        begin
                            case ($urandom_range(0, 2))
                                0:       it.did = DID_T2_OK_A;
                                1:       it.did = DID_T2_OK_B;
                                default: it.did = DID_T2_OK_C;
                            endcase
                        end
                        default: it.did = 8'($urandom_range(8'h10, 8'h7F));
                    endcase
                    if (!it.did[7])
                        it.second_byte = 8'($urandom_range(1, 255));
                end
                else
                    it.did = 8'($urandom_range(1, 255));
                if (!it.did[7])
                    it.type1_only = 1'b0;
                run_item(it, 1'b0, '0);

                for (int w = 0; w < cut; w++)
                begin
                    it = scramble();
                    it.operation = OP_WORD;
                    it.user_word = {2'($urandom_range(0, 2)), 8'($urandom)};
                    if (w == spoil)
                        it.user_word[9:8] = WORD_BAD_TOP;
                    run_item(it, 1'b0, '0);
                    if (w == spoil)
                        break;
                end
            end
            else if (kind < 87)
            begin
                // Noise header with every field random.
                it = scramble();
                it.operation = OP_HEADER;
                run_item(it, 1'b0, '0);
            end
            else
            begin
                // Stray word, which may land inside or outside a packet.
                it = scramble();
                it.operation = OP_WORD;
                run_item(it, 1'b0, '0);
            end
        end

        // Let every expected byte drain, then allow the pipeline to settle.
        push <= 1'b0;
        calm = 1'b0;
        while (bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);

        $display("Ran %0d items over %0d mode writes: %0d bytes checked.",
                 items_run, mode_writes, bytes_checked);
        $display("Saw %0d closed packets and %0d error results; %0d mismatches.",
                 packets_closed, refusals, mismatches);
        if (mismatches == 0)
            $display("tb_anc_packet_word_packer OK");
        else
            $display("tb_anc_packet_word_packer NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
design/anc_pw_pkg.sv
design/anc_pw_front.sv
design/anc_pw_fifo.sv
design/anc_pw_back.sv
design/anc_packet_word_packer.sv
design/anc_pw_checker.sv
tb/sv/tb_anc_packet_word_packer.sv
